@@ rtl/core/aapr_pkg.sv @@
package aapr_pkg;

    // Field widths
    localparam int COORD_WIDTH      = 16;
    localparam int ANGLE_BITS       = 16;
    localparam int TRIG_TABLE_DEPTH = 1024;
    localparam int AXIS_WIDTH       = 16;
    localparam int ANGLE_IN_WIDTH   = 16;

    // Fixed-point scaling
    localparam int ONE_Q14   = 16384;
    localparam int Q14_SHIFT = 14;
    localparam int TRIG_W    = Q14_SHIFT + 1;            // ROM word, 0 .. 1.0
    localparam int ROM_AW    = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int IDX_W     = $clog2(TRIG_TABLE_DEPTH);
    localparam int FRAC_W    = ANGLE_BITS - 2;

    // Stream packing
    localparam int S_TDATA_RAW = 3 * COORD_WIDTH + 3 * AXIS_WIDTH + ANGLE_IN_WIDTH;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW = 3 * COORD_WIDTH;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TUSER_W   = 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [TRIG_W-1:0] sine_rom_t [TRIG_TABLE_DEPTH+1];

    // Quarter-wave sine table in Q1.14, built from a Taylor series at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned t;
        longint          s;
        longint          v;
        int              n;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * 64'(k) + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
            t = x;
            s = longint'(x);
            for (n = 1; n <= 16 && t != 0; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    s = s - longint'(t);
                end else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (s + 32768) >>> 16;
            if (v > ONE_Q14) begin
                v = ONE_Q14;
            end
            rom[k] = TRIG_W'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/core/axis_angle_point_rotation_unit.sv @@
// Channel | Dir | Signals                 | Contents
// s_      | in  | tvalid tready tdata     | point x,y,z (Q8.8), axis x,y,z (Q1.14), turn angle
// m_      | out | tvalid tready tdata tuser| rotated x,y,z (Q8.8); tuser: clipped flag
//
// Eight register stages, one transaction per cycle sustained while m_tready is high.
// Stage 1 registers the input, stage 2 reads the 1025-entry sine table (registered),
// then matrix products, rounding, point products, sum and saturation follow.
// aresetn (synchronous, active low) empties the pipeline; payload is not reset.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up behind a stalled output and nothing is lost or repeated.
module axis_angle_point_rotation_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // point_x, point_y, point_z, axis_x, axis_y, axis_z, turn_angle
    input  logic [aapr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [aapr_pkg::M_TDATA_W-1:0] m_tdata,
    // clipped
    output logic [aapr_pkg::M_TUSER_W-1:0] m_tuser
);
    import aapr_pkg::*;

    localparam int NUM_STAGES = 8;
    localparam int LAST       = NUM_STAGES - 1;
    localparam int CW         = COORD_WIDTH;
    localparam int AX_OFF     = 3 * CW;
    localparam int ANG_OFF    = 3 * CW + 3 * AXIS_WIDTH;
    localparam int IDXP_W     = FRAC_W + IDX_W + 1;

    localparam int SC_W      = TRIG_W + 1;
    localparam int OMC_W     = TRIG_W + 2;
    localparam int UU_W      = 2 * AXIS_WIDTH;
    localparam int US_W      = AXIS_WIDTH + SC_W;
    localparam int UUOMC_W   = UU_W + OMC_W;
    localparam int M_W       = UUOMC_W + 1;
    localparam int MAT_SHIFT = 22;
    localparam int MQ_W      = M_W - MAT_SHIFT;
    localparam int C_SHIFT   = 2 * Q14_SHIFT;
    localparam int PROD_W    = MQ_W + CW;
    localparam int ACC_W     = PROD_W + 2;
    localparam int OUT_SHIFT = 20;
    localparam int RND_W     = ACC_W - OUT_SHIFT;

    localparam logic signed [RND_W-1:0] SAT_HI =
        RND_W'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO =
        RND_W'(-(longint'(1) <<< (CW - 1)));
    localparam logic [CW-1:0] OUT_MAX = CW'(SAT_HI);
    localparam logic [CW-1:0] OUT_MIN = CW'(SAT_LO);

    // Axis pair products: xx, yy, zz, xy, xz, yz
    localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};
    // Pair used by matrix entry 3*i+j
    localparam int PAIR_OF [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Handshake and valid chain
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[LAST] = !v_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[LAST];

    // Stage 1: unpack input, angle to quadrant and table index
    logic signed [CW-1:0]         p0_reg [3];
    logic signed [AXIS_WIDTH-1:0] u0_reg [3];
    logic [1:0]                   quad0_reg;
    logic [IDX_W-1:0]             idx0_reg;
    logic [ANGLE_BITS-1:0]        ang;
    logic [IDXP_W-1:0]            idx_scaled;
    logic [IDX_W-1:0]             idx_next;

    always_comb begin
        ang        = ANGLE_BITS'(s_tdata[ANG_OFF +: ANGLE_IN_WIDTH]);
        idx_scaled = (IDXP_W'(ang[FRAC_W-1:0]) * IDXP_W'(TRIG_TABLE_DEPTH)) >> FRAC_W;
        idx_next   = idx_scaled[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                p0_reg[i] <= s_tdata[i*CW +: CW];
                u0_reg[i] <= s_tdata[AX_OFF + i*AXIS_WIDTH +: AXIS_WIDTH];
            end
            quad0_reg <= ang[ANGLE_BITS-1 -: 2];
            idx0_reg  <= idx_next;
        end
    end

    // Stage 2: sine table read for sine and cosine
    logic [TRIG_W-1:0]            sn1_reg;
    logic [TRIG_W-1:0]            cs1_reg;
    logic signed [CW-1:0]         p1_reg [3];
    logic signed [AXIS_WIDTH-1:0] u1_reg [3];
    logic [1:0]                   quad1_reg;
    logic [ROM_AW-1:0]            cos_idx;

    assign cos_idx = ROM_AW'(TRIG_TABLE_DEPTH) - ROM_AW'(idx0_reg);

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            sn1_reg   <= SINE_ROM[ROM_AW'(idx0_reg)];
            cs1_reg   <= SINE_ROM[cos_idx];
            p1_reg    <= p0_reg;
            u1_reg    <= u0_reg;
            quad1_reg <= quad0_reg;
        end
    end

    // Stage 3: quadrant fold, 1 - cos, axis pair products
    logic signed [SC_W-1:0]       s2_reg;
    logic signed [SC_W-1:0]       c2_reg;
    logic signed [OMC_W-1:0]      omc2_reg;
    logic signed [UU_W-1:0]       uu2_reg [6];
    logic signed [CW-1:0]         p2_reg [3];
    logic signed [AXIS_WIDTH-1:0] u2_reg [3];
    logic signed [SC_W-1:0]       sn_s;
    logic signed [SC_W-1:0]       cs_s;
    logic signed [SC_W-1:0]       s_next;
    logic signed [SC_W-1:0]       c_next;
    logic signed [OMC_W-1:0]      omc_next;
    logic signed [UU_W-1:0]       uu_next [6];

    always_comb begin
        sn_s = $signed(SC_W'(sn1_reg));
        cs_s = $signed(SC_W'(cs1_reg));
        unique case (quad1_reg)
            QUAD_0: begin
                s_next = sn_s;
                c_next = cs_s;
            end
            QUAD_1: begin
                s_next = cs_s;
                c_next = -sn_s;
            end
            QUAD_2: begin
                s_next = -sn_s;
                c_next = -cs_s;
            end
            QUAD_3: begin
                s_next = -cs_s;
                c_next = sn_s;
            end
            default: begin
                s_next = sn_s;
                c_next = cs_s;
            end
        endcase
        omc_next = OMC_W'(ONE_Q14) - OMC_W'(c_next);
        for (int k = 0; k < 6; k++) begin
            uu_next[k] = UU_W'(u1_reg[PAIR_A[k]]) * UU_W'(u1_reg[PAIR_B[k]]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_reg   <= s_next;
            c2_reg   <= c_next;
            omc2_reg <= omc_next;
            uu2_reg  <= uu_next;
            p2_reg   <= p1_reg;
            u2_reg   <= u1_reg;
        end
    end

    // Stage 4: pair products times (1 - cos), axis times sine
    logic signed [UUOMC_W-1:0] uuomc3_reg [6];
    logic signed [US_W-1:0]    us3_reg [3];
    logic signed [SC_W-1:0]    c3_reg;
    logic signed [CW-1:0]      p3_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            for (int k = 0; k < 6; k++) begin
                uuomc3_reg[k] <= UUOMC_W'(uu2_reg[k]) * UUOMC_W'(omc2_reg);
            end
            for (int k = 0; k < 3; k++) begin
                us3_reg[k] <= US_W'(u2_reg[k]) * US_W'(s2_reg);
            end
            c3_reg <= c2_reg;
            p3_reg <= p2_reg;
        end
    end

    // Stage 5: matrix entries at 2^-42, rounded to Q.20
    logic signed [MQ_W-1:0] mq4_reg [9];
    logic signed [CW-1:0]   p4_reg [3];
    logic signed [M_W-1:0]  mat [9];
    logic signed [M_W-1:0]  skew [3];
    logic signed [M_W-1:0]  mat_rnd [9];
    logic signed [MQ_W-1:0] mq_next [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            skew[k] = M_W'(us3_reg[k]) <<< Q14_SHIFT;
        end
        for (int k = 0; k < 9; k++) begin
            mat[k] = M_W'(uuomc3_reg[PAIR_OF[k]]);
        end
        // cos on the diagonal
        mat[0] = mat[0] + (M_W'(c3_reg) <<< C_SHIFT);
        mat[4] = mat[4] + (M_W'(c3_reg) <<< C_SHIFT);
        mat[8] = mat[8] + (M_W'(c3_reg) <<< C_SHIFT);
        // cross-product matrix of the axis times sine
        mat[1] = mat[1] - skew[2];
        mat[3] = mat[3] + skew[2];
        mat[2] = mat[2] + skew[1];
        mat[6] = mat[6] - skew[1];
        mat[5] = mat[5] - skew[0];
        mat[7] = mat[7] + skew[0];
        for (int k = 0; k < 9; k++) begin
            mat_rnd[k] = mat[k] + (M_W'(1) <<< (MAT_SHIFT - 1));
            mq_next[k] = mat_rnd[k][M_W-1:MAT_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            mq4_reg <= mq_next;
            p4_reg  <= p3_reg;
        end
    end

    // Stage 6: matrix entry times point coordinate
    logic signed [PROD_W-1:0] prod5_reg [9];

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod5_reg[3*i+j] <= PROD_W'(mq4_reg[3*i+j]) * PROD_W'(p4_reg[j]);
                end
            end
        end
    end

    // Stage 7: row sums rounded to Q8.8
    logic signed [RND_W-1:0] rnd6_reg [3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [RND_W-1:0] rnd_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = ACC_W'(prod5_reg[3*i]) + ACC_W'(prod5_reg[3*i+1])
                   + ACC_W'(prod5_reg[3*i+2]) + (ACC_W'(1) <<< (OUT_SHIFT - 1));
            rnd_next[i] = acc[i][ACC_W-1:OUT_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            rnd6_reg <= rnd_next;
        end
    end

    // Stage 8: saturation into the output register
    logic [CW-1:0] out_reg [3];
    logic          clip_reg;
    logic [CW-1:0] out_next [3];
    logic          clip_next;

    always_comb begin
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (rnd6_reg[i] > SAT_HI) begin
                out_next[i] = OUT_MAX;
                clip_next   = 1'b1;
            end else if (rnd6_reg[i] < SAT_LO) begin
                out_next[i] = OUT_MIN;
                clip_next   = 1'b1;
            end else begin
                out_next[i] = CW'(rnd6_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            out_reg  <= out_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tdata = M_TDATA_W'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_tuser = M_TUSER_W'(clip_reg);

    // Checks
    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg && !m_tready) |-> !s_tready)
        else $error("input taken while every stage is full and output stalled");

    a_empty_entry_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_tready)
        else $error("input stage empty but not ready");

    a_accept_fills_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_clip_means_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (out_reg[0] == OUT_MAX || out_reg[0] == OUT_MIN ||
             out_reg[1] == OUT_MAX || out_reg[1] == OUT_MIN ||
             out_reg[2] == OUT_MAX || out_reg[2] == OUT_MIN))
        else $error("clipped flag set without a saturated coordinate");

endmodule
